/* sv/rau_pkg.sv */
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int OPERAND_BITS_DEF = 16;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_CMP = 3'd4,
		OP_NEG = 3'd5,
		OP_INC = 3'd6,
		OP_DEC = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		CMP_EQ = 2'd0,
		CMP_GT = 2'd1,
		CMP_LT = 2'd2
	} cmp_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

/* sv/rau_queue.sv */
// ----------------------------------------------------------------------------
// rau_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module rau_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output rau_pkg::q_stat_t stat
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wp_q;
	logic             rp_q;
	logic [1:0]       cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	assign rdata      = mem_q[rp_q];
	assign stat.full  = cnt_q == 2'd2;
	assign stat.empty = cnt_q == 2'd0;

endmodule

/* sv/rau_front.sv */
// ----------------------------------------------------------------------------
// rau_front
// Accepts a command word, forms the cross products and the unreduced result.
// ----------------------------------------------------------------------------
module rau_front #(
	parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF,
	localparam int N = OPERAND_BITS,
	localparam int W = 2 * OPERAND_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [2:0]          op,
	input  logic signed [N-1:0] a_num,
	input  logic [N-2:0]        a_den,
	input  logic signed [N-1:0] b_num,
	input  logic [N-2:0]        b_den,
	input  logic                q_full,
	output logic                push,
	output logic [2*W+1:0]      word
);

	logic                v_s1, v_s2;
	rau_pkg::op_t        op_s1, op_s2;
	logic signed [N-1:0] an_s1, bn_s1, an_s2;
	logic [N-2:0]        ad_s1, bd_s1, ad_s2;
	logic                bz_s2;
	logic signed [W-1:0] pa_s2, pb_s2;
	logic [W-2:0]        pc_s2;

	logic                s2_free, mv1, acc;
	logic signed [N-1:0] msel, ads;
	logic signed [W-1:0] pa, pb;

	assign push    = v_s2 && !q_full;
	assign s2_free = !v_s2 || push;
	assign mv1     = v_s1 && s2_free;
	assign busy    = v_s1 && !s2_free;
	assign acc     = start && !busy;

	// multiply uses b_num where the others use b_den
	assign msel = (op_s1 == rau_pkg::OP_MUL) ? bn_s1 : $signed({1'b0, bd_s1});
	assign ads  = $signed({1'b0, ad_s1});
	assign pa   = W'(an_s1) * W'(msel);
	assign pb   = W'(bn_s1) * W'(ads);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= acc || (v_s1 && !mv1);
			v_s2 <= mv1 || (v_s2 && !push);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1 <= rau_pkg::op_t'(op);
			an_s1 <= a_num;
			bn_s1 <= b_num;
			ad_s1 <= (a_den == '0) ? (N-1)'(1) : a_den;
			bd_s1 <= (b_den == '0) ? (N-1)'(1) : b_den;
		end
		if (mv1) begin
			op_s2 <= op_s1;
			an_s2 <= an_s1;
			ad_s2 <= ad_s1;
			bz_s2 <= bn_s1 == '0;
			pa_s2 <= pa;
			pb_s2 <= pb;
			pc_s2 <= (W-1)'(ad_s1) * (W-1)'(bd_s1);
		end
	end

	logic signed [W-1:0] rn;
	logic [W-2:0]        rd;
	rau_pkg::cmp_t       cmp;
	logic                dz;
	logic signed [W-1:0] anx, adx;

	assign anx = W'(an_s2);
	assign adx = $signed(W'(ad_s2));

	always_comb begin
		rn  = '0;
		rd  = (W-1)'(1);
		cmp = rau_pkg::CMP_EQ;
		dz  = 1'b0;
		case (op_s2)
			rau_pkg::OP_ADD: begin
				rn = pa_s2 + pb_s2;
				rd = pc_s2;
			end
			rau_pkg::OP_SUB: begin
				rn = pa_s2 - pb_s2;
				rd = pc_s2;
			end
			rau_pkg::OP_MUL: begin
				rn = pa_s2;
				rd = pc_s2;
			end
			rau_pkg::OP_DIV: begin
				if (bz_s2) begin
					dz = 1'b1;
				end else if (pb_s2 < 0) begin
					rn = -pa_s2;
					rd = (W-1)'(-pb_s2);
				end else begin
					rn = pa_s2;
					rd = (W-1)'(pb_s2);
				end
			end
			rau_pkg::OP_CMP: begin
				if (pa_s2 > pb_s2) cmp = rau_pkg::CMP_GT;
				else if (pa_s2 < pb_s2) cmp = rau_pkg::CMP_LT;
			end
			rau_pkg::OP_NEG: begin
				rn = -anx;
				rd = (W-1)'(ad_s2);
			end
			rau_pkg::OP_INC: begin
				rn = anx + adx;
				rd = (W-1)'(ad_s2);
			end
			rau_pkg::OP_DEC: begin
				rn = anx - adx;
				rd = (W-1)'(ad_s2);
			end
			default: begin
				rn = '0;
			end
		endcase
	end

	assign word = {dz, cmp, rd, rn};

endmodule

/* sv/rau_divider.sv */
// ----------------------------------------------------------------------------
// rau_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_divider #(
	parameter int W = 32,
	localparam int CW = $clog2(W + 1)
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quot,
	output logic [W-1:0] rem
);

	logic          run_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q, quo_q, dvs_q;
	logic [W:0]    trial, diff;
	logic          ge;

	assign trial = {rem_q, quo_q[W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !run_q) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !run_q) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

/* sv/rau_back.sv */
// ----------------------------------------------------------------------------
// rau_back
// Reduces each queued fraction by its gcd and drives the result word.
// ----------------------------------------------------------------------------
module rau_back #(
	parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF,
	localparam int W = 2 * OPERAND_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rau_pkg::q_stat_t    qstat,
	input  logic [2*W+1:0]      word,
	output logic                pop,
	output logic                done,
	output logic signed [W-1:0] res_num,
	output logic [W-2:0]        res_den,
	output logic [1:0]          cmp_code,
	output logic                div_zero
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_GCD  = 4'b0010,
		S_DIVN = 4'b0100,
		S_DIVD = 4'b1000
	} state_t;

	state_t       st_q;
	logic         neg_q;
	logic [W-1:0] mag_q, den_q, y_q, qn_q;
	logic         done_q;

	logic signed [W-1:0] wnum;
	logic [W-2:0]        wden;
	logic [W-1:0]        wmag;
	logic                dv_start, dv_done;
	logic [W-1:0]        dv_a, dv_b, dv_quot, dv_rem;

	assign wnum = $signed(word[W-1:0]);
	assign wden = word[2*W-2:W];
	assign wmag = wnum[W-1] ? W'(-wnum) : W'(wnum);
	assign pop  = (st_q == S_IDLE) && !qstat.empty;

	always_comb begin
		dv_start = 1'b0;
		dv_a     = mag_q;
		dv_b     = y_q;
		case (st_q)
			S_IDLE: begin
				dv_start = pop && (wnum != '0);
				dv_a     = wmag;
				dv_b     = {1'b0, wden};
			end
			S_GCD: begin
				dv_start = dv_done;
				if (dv_rem == '0) begin
					dv_a = mag_q;
					dv_b = y_q;
				end else begin
					dv_a = y_q;
					dv_b = dv_rem;
				end
			end
			S_DIVN: begin
				dv_start = dv_done;
				dv_a     = den_q;
				dv_b     = y_q;
			end
			S_DIVD: begin
				dv_start = 1'b0;
			end
			default: begin
				dv_start = 1'b0;
			end
		endcase
	end

	rau_divider #(.W(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dv_start),
		.dividend (dv_a),
		.divisor  (dv_b),
		.done     (dv_done),
		.quot     (dv_quot),
		.rem      (dv_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (pop) begin
						if (wnum == '0) done_q <= 1'b1;
						else st_q <= S_GCD;
					end
				end
				S_GCD: begin
					if (dv_done && dv_rem == '0) st_q <= S_DIVN;
				end
				S_DIVN: begin
					if (dv_done) st_q <= S_DIVD;
				end
				S_DIVD: begin
					if (dv_done) begin
						st_q   <= S_IDLE;
						done_q <= 1'b1;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				if (pop) begin
					neg_q    <= wnum[W-1];
					mag_q    <= wmag;
					den_q    <= {1'b0, wden};
					y_q      <= {1'b0, wden};
					cmp_code <= word[2*W:2*W-1];
					div_zero <= word[2*W+1];
					// zero numerator comes out as 0/1
					res_num  <= '0;
					res_den  <= (W-1)'(1);
				end
			end
			S_GCD: begin
				// gcd ends up in y_q once the remainder is zero
				if (dv_done && dv_rem != '0) y_q <= dv_rem;
			end
			S_DIVN: begin
				if (dv_done) qn_q <= dv_quot;
			end
			S_DIVD: begin
				if (dv_done) begin
					res_num <= neg_q ? $signed(-qn_q) : $signed(qn_q);
					res_den <= dv_quot[W-2:0];
				end
			end
			default: begin
				neg_q <= neg_q;
			end
		endcase
	end

	assign done = done_q;

endmodule

/* sv/rational_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Rational add, sub, mul, div, compare and unary ops with gcd reduction.
// ----------------------------------------------------------------------------
// Usage: drive op and both operands and raise start; the command word is taken
// at a rising edge where start is high and busy is low. Denominator fields of
// zero are read as one.
// The front registers the operands, registers the cross products in a second
// stage and writes the unreduced fraction into a two-entry queue. The back
// pops it and reduces it with a shared one-bit-per-cycle divider: the gcd is
// found by repeated modulo steps, then numerator and denominator are each
// divided by the gcd in the same unit. Zero results, compares and divide by
// zero skip the divider. The back pops the next word only once it is idle
// again, so the divider sets the throughput.
// Each result word is on res_num, res_den, cmp_code and div_zero, marked by a
// one-cycle done pulse; the receiver cannot stall it. busy rises while
// the queue is full and both front stages hold a word.
// Reset clears the pipeline valids, the queue and the back state machine.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
	parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF,
	localparam int N = OPERAND_BITS,
	localparam int W = 2 * OPERAND_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [2:0]          op,
	input  logic signed [N-1:0] a_num,
	input  logic [N-2:0]        a_den,
	input  logic signed [N-1:0] b_num,
	input  logic [N-2:0]        b_den,
	output logic                done,
	output logic signed [W-1:0] res_num,
	output logic [W-2:0]        res_den,
	output logic [1:0]          cmp_code,
	output logic                div_zero
);

	logic                 push, pop;
	logic [2*W+1:0]       wword, rword;
	rau_pkg::q_stat_t     qstat;

	rau_front #(.OPERAND_BITS(OPERAND_BITS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.op     (op),
		.a_num  (a_num),
		.a_den  (a_den),
		.b_num  (b_num),
		.b_den  (b_den),
		.q_full (qstat.full),
		.push   (push),
		.word   (wword)
	);

	rau_queue #(.WIDTH(2 * W + 2)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wword),
		.pop    (pop),
		.rdata  (rword),
		.stat   (qstat)
	);

	rau_back #(.OPERAND_BITS(OPERAND_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.word     (rword),
		.pop      (pop),
		.done     (done),
		.res_num  (res_num),
		.res_den  (res_den),
		.cmp_code (cmp_code),
		.div_zero (div_zero)
	);

endmodule
